// ----- rtl/core/bars_pkg.sv -----
// Shared types and constants of the band analyzer readout sequencer.
// Depends on nothing; every other file of the block imports it.
package bars_pkg;

  // Fixed channel field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned PCT_W      = 7;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_PULSE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEAD_IN         = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STROBE_PULSE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BAND_GAP        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_GAP       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BLEND_PERCENT   = 3'd6;

  // Register reset values
  localparam logic [DELAY_W-1:0] RST_RESET_PULSE     = 16'd10;
  localparam logic [DELAY_W-1:0] RST_LEAD_IN         = 16'd200;
  localparam logic [DELAY_W-1:0] RST_STROBE_PULSE    = 16'd100;
  localparam logic [DELAY_W-1:0] RST_SETTLE          = 16'd100;
  localparam logic [DELAY_W-1:0] RST_BAND_GAP        = 16'd100;
  localparam logic [DELAY_W-1:0] RST_FRAME_GAP       = 16'd1000;
  localparam logic [PCT_W-1:0]   RST_BLEND_PERCENT   = 7'd50;

  typedef enum logic [4:0] {
    PH_RESET_ON   = 5'b00001,
    PH_RESET_OFF  = 5'b00010,
    PH_STROBE_ON  = 5'b00100,
    PH_STROBE_OFF = 5'b01000,
    PH_READ       = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [DELAY_W-1:0] reset_pulse;
    logic [DELAY_W-1:0] lead_in;
    logic [DELAY_W-1:0] strobe_pulse;
    logic [DELAY_W-1:0] settle;
    logic [DELAY_W-1:0] band_gap;
    logic [DELAY_W-1:0] frame_gap;
  } delays_t;

  // Per-tick control flags that ride along with the blend
  typedef struct packed {
    logic reset_level;
    logic strobe_level;
    logic band_valid;
    logic frame_done;
  } ctl_t;

  // Countdown reload: a delay of 0 behaves like 1
  function automatic logic [DELAY_W-1:0] load_delay(input logic [DELAY_W-1:0] d);
    return (d == '0) ? '0 : d - 16'd1;
  endfunction

endpackage

// ----- rtl/core/bars_if.sv -----
// Channel interfaces of the band analyzer readout sequencer: sample in,
// result out, and configuration writes. Depends on bars_pkg.
interface bars_in_if;
  import bars_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bars_out_if;
  import bars_pkg::*;
  logic                valid;
  logic                ready;
  logic                reset_level;
  logic                strobe_level;
  logic                band_valid;
  logic [INDEX_W-1:0]  band_index;
  logic [SAMPLE_W-1:0] band_value;
  logic                frame_done;
  modport source (output valid, output reset_level, output strobe_level,
                  output band_valid, output band_index, output band_value,
                  output frame_done, input ready);
  modport sink   (input valid, input reset_level, input strobe_level,
                  input band_valid, input band_index, input band_value,
                  input frame_done, output ready);
endinterface

interface bars_cfg_if;
  import bars_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bars_phase_ctrl.sv -----
// Reset/strobe phase machine with per-phase countdown and band counter.
// Depends on bars_pkg.
module bars_phase_ctrl #(
  parameter int unsigned NUM_BANDS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  bars_pkg::delays_t             delays,
  output bars_pkg::ctl_t                tick_ctl,
  output logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] band_idx
);
  import bars_pkg::*;

  localparam int unsigned BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

  phase_t             phase, phase_next;
  logic [DELAY_W-1:0] delay_left, delay_left_next;
  logic [BAND_W-1:0]  current_band, current_band_next;
  logic               reset_line, reset_line_next;
  logic               strobe_line, strobe_line_next;
  logic               read_now, last_now;

  always_comb begin
    phase_next        = phase;
    delay_left_next   = delay_left;
    current_band_next = current_band;
    reset_line_next   = reset_line;
    strobe_line_next  = strobe_line;
    read_now          = 1'b0;
    last_now          = 1'b0;
    band_idx          = '0;
    if (tick) begin
      if (delay_left != '0) begin
        delay_left_next = delay_left - 16'd1;
      end else begin
        unique case (phase)
          PH_RESET_OFF: begin
            reset_line_next = 1'b0;
            phase_next      = PH_STROBE_ON;
            delay_left_next = load_delay(delays.lead_in);
          end
          PH_STROBE_ON: begin
            strobe_line_next = 1'b1;
            phase_next       = PH_STROBE_OFF;
            delay_left_next  = load_delay(delays.strobe_pulse);
          end
          PH_STROBE_OFF: begin
            strobe_line_next = 1'b0;
            phase_next       = PH_READ;
            delay_left_next  = load_delay(delays.settle);
          end
          PH_READ: begin
            read_now = 1'b1;
            band_idx = current_band;
            if (current_band == LAST_BAND) begin
              last_now          = 1'b1;
              current_band_next = '0;
              phase_next        = PH_RESET_ON;
              delay_left_next   = load_delay(delays.frame_gap);
            end else begin
              current_band_next = current_band + BAND_W'(1);
              phase_next        = PH_STROBE_ON;
              delay_left_next   = load_delay(delays.band_gap);
            end
          end
          default: begin
            // reset-high action, also taken from any stray code
            current_band_next = '0;
            reset_line_next   = 1'b1;
            phase_next        = PH_RESET_OFF;
            delay_left_next   = load_delay(delays.reset_pulse);
          end
        endcase
      end
    end
  end

  always_comb begin
    tick_ctl.reset_level  = reset_line_next;
    tick_ctl.strobe_level = strobe_line_next;
    tick_ctl.band_valid   = read_now;
    tick_ctl.frame_done   = last_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RESET_ON;
      delay_left   <= '0;
      current_band <= '0;
      reset_line   <= 1'b0;
      strobe_line  <= 1'b0;
    end else begin
      phase        <= phase_next;
      delay_left   <= delay_left_next;
      current_band <= current_band_next;
      reset_line   <= reset_line_next;
      strobe_line  <= strobe_line_next;
    end
  end

  // Strobe only rises after reset has dropped.
  a_lines_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(reset_line && strobe_line))
    else $error("reset and strobe lines high together");

  a_band_in_range: assert property (@(posedge clk) disable iff (rst)
    current_band <= LAST_BAND)
    else $error("band counter past last band");

  a_frame_done_last: assert property (@(posedge clk) disable iff (rst)
    tick_ctl.frame_done |-> tick_ctl.band_valid && band_idx == LAST_BAND)
    else $error("frame done without last band read");

endmodule

// ----- rtl/core/bars_blend.sv -----
// Three-stage smoothing pipeline with the band store: weighted products,
// divide by 100 via reciprocal, then sum. Depends on bars_pkg.
module bars_blend #(
  parameter int unsigned NUM_BANDS   = 7,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bars_pkg::ctl_t                in_ctl,
  input  logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] in_idx,
  input  logic [SAMPLE_BITS-1:0]        in_x,
  input  logic [bars_pkg::PCT_W-1:0]    blend_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bars_pkg::ctl_t                out_ctl,
  output logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] out_idx,
  output logic [SAMPLE_BITS-1:0]        out_value
);
  import bars_pkg::*;

  localparam int unsigned BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  // product x*pct stays below 2^PW
  localparam int unsigned PW  = SAMPLE_BITS + PCT_W;
  // floor(p/100) == (p*RECIP) >> RK, exact for every p below 2^PW
  localparam int unsigned RK  = PW + 7;
  localparam int unsigned RW  = RK - 6;
  localparam int unsigned PRW = PW + RW;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RK) + 64'd99) / 64'd100);

  logic [SAMPLE_BITS-1:0] store [NUM_BANDS];

  logic [PCT_W-1:0] alpha, beta;
  logic             s1_en, s2_en, out_en;

  logic                   s1_valid;
  ctl_t                   s1_ctl;
  logic [BAND_W-1:0]      s1_idx;
  logic [PW-1:0]          s1_px, s1_po;

  logic                   s2_valid;
  ctl_t                   s2_ctl;
  logic [BAND_W-1:0]      s2_idx;
  logic [SAMPLE_BITS-1:0] s2_qx, s2_qo;

  logic [PRW-1:0]         prod_x, prod_o;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] blended;
  logic                   store_we;

  assign alpha = (blend_percent > PCT_FULL) ? PCT_FULL : blend_percent;
  assign beta  = PCT_FULL - alpha;

  assign out_en   = !out_valid || out_ready;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  assign prod_x = PRW'(s1_px) * PRW'(RECIP);
  assign prod_o = PRW'(s1_po) * PRW'(RECIP);

  assign sum      = (SAMPLE_BITS + 1)'(s2_qx) + (SAMPLE_BITS + 1)'(s2_qo);
  assign blended  = sum[SAMPLE_BITS] ? '1 : sum[SAMPLE_BITS-1:0];
  assign store_we = out_en && s2_valid && s2_ctl.band_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_valid  <= in_valid;
      if (s2_en)  s2_valid  <= s1_valid;
      if (out_en) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ctl <= in_ctl;
      s1_idx <= in_idx;
      s1_px  <= PW'(in_x) * PW'(alpha);
      s1_po  <= PW'(store[in_idx]) * PW'(beta);
    end
    if (s2_en) begin
      s2_ctl <= s1_ctl;
      s2_idx <= s1_idx;
      s2_qx  <= SAMPLE_BITS'(prod_x >> RK);
      s2_qo  <= SAMPLE_BITS'(prod_o >> RK);
    end
    if (out_en) begin
      out_ctl   <= s2_ctl;
      out_idx   <= s2_idx;
      out_value <= s2_ctl.band_valid ? blended : '0;
    end
  end

  // Band store is cleared at reset; a band is read again only after its
  // write-back has completed, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) store[i] <= '0;
    end else if (store_we) begin
      store[s2_idx] <= blended;
    end
  end

  a_s1_loaded: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction lost at stage one");

  a_no_hazard_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ctl.band_valid && s2_valid && s2_ctl.band_valid
      |-> s1_idx != s2_idx)
    else $error("same band read before write-back");

  a_no_hazard_s2: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_ctl.band_valid && out_valid && out_ctl.band_valid
      |-> s2_idx != out_idx)
    else $error("same band in flight twice");

endmodule

// ----- rtl/core/band_analyzer_readout_sequencer.sv -----
// Band analyzer readout sequencer, top level. An accepted sample passes the
// stage-one, stage-two and output registers. Throughput is one transaction
// per cycle unless result.ready stalls, set by the three-stage blend pipeline.
// Reset (rst, sync, active high) loads default delays, clears the band store
// and restarts the phase machine at the reset-high action with both lines low.
// Depends on bars_pkg, bars_if, bars_phase_ctrl, bars_blend.
module band_analyzer_readout_sequencer #(
  parameter int unsigned NUM_BANDS   = 7,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  bars_cfg_if.sink    cfg,
  bars_in_if.sink     sample,
  bars_out_if.source  result
);
  import bars_pkg::*;

  localparam int unsigned BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  // Configuration registers; cfg.ready is held high, so writes are always accepted.
  delays_t          delays;
  logic [PCT_W-1:0] blend_percent;
  logic             cfg_we;

  // Per-tick control from the phase machine
  logic              tick;
  ctl_t              tick_ctl;
  logic [BAND_W-1:0] tick_idx;

  // Pipeline output
  ctl_t                   res_ctl;
  logic [BAND_W-1:0]      res_idx;
  logic [SAMPLE_BITS-1:0] res_value;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delays.reset_pulse     <= RST_RESET_PULSE;
      delays.lead_in         <= RST_LEAD_IN;
      delays.strobe_pulse    <= RST_STROBE_PULSE;
      delays.settle          <= RST_SETTLE;
      delays.band_gap        <= RST_BAND_GAP;
      delays.frame_gap       <= RST_FRAME_GAP;
      blend_percent          <= RST_BLEND_PERCENT;
    end else if (cfg_we) begin
      unique case (cfg.index)
        REG_RESET_PULSE:     delays.reset_pulse     <= cfg.data;
        REG_LEAD_IN:         delays.lead_in         <= cfg.data;
        REG_STROBE_PULSE:    delays.strobe_pulse    <= cfg.data;
        REG_SETTLE:          delays.settle          <= cfg.data;
        REG_BAND_GAP:        delays.band_gap        <= cfg.data;
        REG_FRAME_GAP:       delays.frame_gap       <= cfg.data;
        REG_BLEND_PERCENT:   blend_percent          <= cfg.data[PCT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // One accepted sample transaction is one microsecond tick.
  assign tick = sample.valid && sample.ready;

  bars_phase_ctrl #(
    .NUM_BANDS (NUM_BANDS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .delays   (delays),
    .tick_ctl (tick_ctl),
    .band_idx (tick_idx)
  );

  // Only the low SAMPLE_BITS of the converter reading take part.
  bars_blend #(
    .NUM_BANDS   (NUM_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .in_ctl        (tick_ctl),
    .in_idx        (tick_idx),
    .in_x          (sample.adc_sample[SAMPLE_BITS-1:0]),
    .blend_percent (blend_percent),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_ctl       (res_ctl),
    .out_idx       (res_idx),
    .out_value     (res_value)
  );

  assign result.reset_level  = res_ctl.reset_level;
  assign result.strobe_level = res_ctl.strobe_level;
  assign result.band_valid   = res_ctl.band_valid;
  assign result.frame_done   = res_ctl.frame_done;
  assign result.band_index   = INDEX_W'(res_idx);
  assign result.band_value   = SAMPLE_W'(res_value);

endmodule
